@@ design/vsp_pkg.sv @@
// ---------------------------------------------------------------------------
// vsp_pkg: shared types and constants for the vertex projection block
// Controller states, datapath command/status structs, register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package vsp_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_X_01 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_X_23 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_Y_01 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_Y_23 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_W_01 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_W_23 = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_VP_ORIGIN = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_VP_SIZE = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SCALE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input word, clear accumulators
        logic mac;       // one multiply-accumulate term
        logic scale;     // one shift-add step of the viewport scaling
        logic prep;      // form numerators and divisor
        logic div;       // one restoring divide step, both axes
        logic fin;       // round/saturate, update box, load output
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mac_done;
        logic scale_done;
        logic div_done;
    } dp_sts_t;

endpackage

`default_nettype wire

@@ design/vsp_ctrl.sv @@
// ---------------------------------------------------------------------------
// vsp_ctrl: sequencing controller
// Steps one vertex through accumulate, scale, prepare, divide and finish phases.
// ---------------------------------------------------------------------------
`default_nettype none

module vsp_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic             out_free,
    input  wire vsp_pkg::dp_sts_t sts,
    output vsp_pkg::dp_cmd_t      cmd,
    output logic                  in_ready
);

    vsp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vsp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            vsp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = vsp_pkg::ST_MAC;
                end
            end
            vsp_pkg::ST_MAC:
            begin
                cmd.mac = 1'b1;
                if (sts.mac_done)
                begin
                    state_next = vsp_pkg::ST_SCALE;
                end
            end
            vsp_pkg::ST_SCALE:
            begin
                cmd.scale = 1'b1;
                if (sts.scale_done)
                begin
                    state_next = vsp_pkg::ST_PREP;
                end
            end
            vsp_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = vsp_pkg::ST_DIV;
            end
            vsp_pkg::ST_DIV:
            begin
                cmd.div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = vsp_pkg::ST_FIN;
                end
            end
            vsp_pkg::ST_FIN:
            begin
                // wait for the output register to be free
                if (out_free)
                begin
                    cmd.fin = 1'b1;
                    state_next = vsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vsp_pkg::ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> state_reg == vsp_pkg::ST_IDLE)
        else $error("finish not followed by idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == vsp_pkg::ST_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cmd) <= 1)
        else $error("more than one datapath command");

endmodule

`default_nettype wire

@@ design/vsp_datapath.sv @@
// ---------------------------------------------------------------------------
// vsp_datapath: projection datapath
// One shared multiplier for the row sums, shift-add viewport scaling, a
// bit-serial divider per axis, rounding, saturation, box and output registers.
// ---------------------------------------------------------------------------
`default_nettype none

module vsp_datapath
#(
    parameter int COORD_BITS = 32,
    parameter int SCREEN_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vsp_pkg::dp_cmd_t              cmd,
    output vsp_pkg::dp_sts_t                   sts,
    input  wire logic signed [COORD_BITS-1:0]  vx,
    input  wire logic signed [COORD_BITS-1:0]  vy,
    input  wire logic signed [COORD_BITS-1:0]  vz,
    input  wire logic                          vfirst,
    input  wire logic                          vlast,
    input  wire logic                          cfg_we,
    input  wire logic [vsp_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
    input  wire logic [vsp_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                          out_take,
    output logic                               out_valid,
    output logic signed [SCREEN_BITS-1:0]      o_sx,
    output logic signed [SCREEN_BITS-1:0]      o_sy,
    output logic signed [SCREEN_BITS-1:0]      o_xmin,
    output logic signed [SCREEN_BITS-1:0]      o_xmax,
    output logic signed [SCREEN_BITS-1:0]      o_ymin,
    output logic signed [SCREEN_BITS-1:0]      o_ymax,
    output logic                               o_last,
    output logic                               o_wz
);

    localparam int PB = COORD_BITS + 32;     // one product
    localparam int AB = PB + 3;              // row sum of four products
    localparam int NB = AB + 20;             // numerator (scaled by up to 2^17, plus margin)
    localparam int QB = NB;                  // quotient / dividend width
    localparam int CB = $clog2(QB + 1);
    localparam int TB = 4;                   // term counter (12 terms)
    localparam int OB = COORD_BITS + 2;      // operand, holds 1.0 (65536) when COORD_BITS >= 16
    localparam logic [TB-1:0] LAST_TERM = TB'(11);
    localparam logic [4:0] LAST_SCALE = 5'd17;
    localparam logic signed [SCREEN_BITS-1:0] SMAX = {1'b0, {(SCREEN_BITS-1){1'b1}}};
    localparam logic signed [SCREEN_BITS-1:0] SMIN = {1'b1, {(SCREEN_BITS-1){1'b0}}};

    // configuration
    logic [63:0] rx01_reg, rx23_reg, ry01_reg, ry23_reg, rw01_reg, rw23_reg;
    logic [31:0] vpo_reg, vps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx01_reg <= 64'd65536;
            rx23_reg <= 64'd0;
            ry01_reg <= 64'd281474976710656;
            ry23_reg <= 64'd0;
            rw01_reg <= 64'd0;
            rw23_reg <= 64'd281474976710656;
            vpo_reg  <= 32'd0;
            vps_reg  <= 32'd70779840;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                vsp_pkg::REG_ROW_X_01:  rx01_reg <= cfg_data;
                vsp_pkg::REG_ROW_X_23:  rx23_reg <= cfg_data;
                vsp_pkg::REG_ROW_Y_01:  ry01_reg <= cfg_data;
                vsp_pkg::REG_ROW_Y_23:  ry23_reg <= cfg_data;
                vsp_pkg::REG_ROW_W_01:  rw01_reg <= cfg_data;
                vsp_pkg::REG_ROW_W_23:  rw23_reg <= cfg_data;
                vsp_pkg::REG_VP_ORIGIN: vpo_reg  <= cfg_data[31:0];
                vsp_pkg::REG_VP_SIZE:   vps_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // captured vertex
    logic signed [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic first_reg, last_reg;
    logic [TB-1:0] term_reg;
    logic signed [AB-1:0] accx_reg, accy_reg, accw_reg;

    // term select: row = term/4, column = term%4
    logic signed [31:0] coef;
    logic signed [OB-1:0] opnd;
    logic [63:0] row01, row23;
    always_comb
    begin
        case (term_reg[3:2])
            2'd0:    begin row01 = rx01_reg; row23 = rx23_reg; end
            2'd1:    begin row01 = ry01_reg; row23 = ry23_reg; end
            default: begin row01 = rw01_reg; row23 = rw23_reg; end
        endcase
        case (term_reg[1:0])
            2'd0:    begin coef = row01[31:0];  opnd = OB'(x_reg); end
            2'd1:    begin coef = row01[63:32]; opnd = OB'(y_reg); end
            2'd2:    begin coef = row23[31:0];  opnd = OB'(z_reg); end
            default: begin coef = row23[63:32]; opnd = OB'(65536); end
        endcase
    end

    logic signed [PB-1:0] prod;
    assign prod = PB'(coef) * PB'(opnd);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= vx;
            y_reg <= vy;
            z_reg <= vz;
            first_reg <= vfirst;
            last_reg <= vlast;
            term_reg <= '0;
            accx_reg <= '0;
            accy_reg <= '0;
            accw_reg <= '0;
        end
        else if (cmd.mac)
        begin
            term_reg <= term_reg + TB'(1);
            case (term_reg[3:2])
                2'd0:    accx_reg <= accx_reg + AB'(prod);
                2'd1:    accy_reg <= accy_reg + AB'(prod);
                default: accw_reg <= accw_reg + AB'(prod);
            endcase
        end
    end

    assign sts.mac_done = term_reg == LAST_TERM;

    // numerators: nx = width*(X+W) + 2*left*W, ny = height*(W-Y) + 2*top*W
    // built MSB first over the 18 bits of the viewport factors
    logic signed [NB-1:0] wx, ww, wy, sumx, sumy, nx_reg, ny_reg;
    logic [17:0] wdt, hgt, lft2, top2;
    logic [4:0] scnt_reg, sbit;
    assign wx  = NB'(accx_reg);
    assign wy  = NB'(accy_reg);
    assign ww  = NB'(accw_reg);
    assign sumx = wx + ww;
    assign sumy = ww - wy;
    assign wdt = {2'b00, vps_reg[15:0]};
    assign hgt = {2'b00, vps_reg[31:16]};
    assign lft2 = {1'b0, vpo_reg[15:0], 1'b0};
    assign top2 = {1'b0, vpo_reg[31:16], 1'b0};
    assign sbit = LAST_SCALE - scnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            scnt_reg <= '0;
            nx_reg <= '0;
            ny_reg <= '0;
        end
        else if (cmd.scale)
        begin
            scnt_reg <= scnt_reg + 5'd1;
            nx_reg <= (nx_reg <<< 1) + (wdt[sbit] ? sumx : '0) + (lft2[sbit] ? ww : '0);
            ny_reg <= (ny_reg <<< 1) + (hgt[sbit] ? sumy : '0) + (top2[sbit] ? ww : '0);
        end
    end

    assign sts.scale_done = scnt_reg == LAST_SCALE;

    logic nxneg_reg, nyneg_reg, dneg_reg, wz_reg;
    logic [QB-1:0] dvx_reg, dvy_reg, dd_reg, qx_reg, qy_reg, rx_reg, ry_reg;
    logic [CB-1:0] cnt_reg;

    logic [QB-1:0] anx, any, ad;
    assign anx = nx_reg[NB-1] ? QB'(-nx_reg) : QB'(nx_reg);
    assign any = ny_reg[NB-1] ? QB'(-ny_reg) : QB'(ny_reg);
    assign ad  = ww[NB-1] ? QB'(-ww) : QB'(ww);

    logic [QB:0] rxs, rys;
    assign rxs = {rx_reg, dvx_reg[QB-1]};
    assign rys = {ry_reg, dvy_reg[QB-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            nxneg_reg <= nx_reg[NB-1];
            nyneg_reg <= ny_reg[NB-1];
            dneg_reg <= ww[NB-1];
            wz_reg <= accw_reg == '0;
            // round(n/d) = floor((2|n| + |d|) / 2|d|) with d = 2W
            dvx_reg <= (anx << 1) + (ad << 1);
            dvy_reg <= (any << 1) + (ad << 1);
            dd_reg <= ad << 2;
            rx_reg <= '0;
            ry_reg <= '0;
            cnt_reg <= CB'(QB);
        end
        else if (cmd.div)
        begin
            cnt_reg <= cnt_reg - CB'(1);
            dvx_reg <= dvx_reg << 1;
            dvy_reg <= dvy_reg << 1;
            if (rxs >= {1'b0, dd_reg})
            begin
                rx_reg <= QB'(rxs - {1'b0, dd_reg});
                qx_reg <= {qx_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rx_reg <= QB'(rxs);
                qx_reg <= {qx_reg[QB-2:0], 1'b0};
            end
            if (rys >= {1'b0, dd_reg})
            begin
                ry_reg <= QB'(rys - {1'b0, dd_reg});
                qy_reg <= {qy_reg[QB-2:0], 1'b1};
            end
            else
            begin
                ry_reg <= QB'(rys);
                qy_reg <= {qy_reg[QB-2:0], 1'b0};
            end
        end
    end

    assign sts.div_done = cnt_reg == CB'(1);

    function automatic logic signed [SCREEN_BITS-1:0] sat(
        input logic [QB-1:0] q, input logic neg);
        logic [QB-1:0] lim;
        lim = QB'(SMAX);
        if (!neg)
            sat = (q > lim) ? SMAX : SCREEN_BITS'(q);
        else
            sat = (q > lim + QB'(1)) ? SMIN : SCREEN_BITS'(-q);
    endfunction

    logic signed [SCREEN_BITS-1:0] sx, sy;
    always_comb
    begin
        if (wz_reg)
        begin
            sx = nxneg_reg ? SMIN : SMAX;
            sy = nyneg_reg ? SMIN : SMAX;
        end
        else
        begin
            sx = sat(qx_reg, nxneg_reg ^ dneg_reg);
            sy = sat(qy_reg, nyneg_reg ^ dneg_reg);
        end
    end

    logic signed [SCREEN_BITS-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic signed [SCREEN_BITS-1:0] xmin_next, xmax_next, ymin_next, ymax_next;
    always_comb
    begin
        xmin_next = (first_reg || sx < xmin_reg) ? sx : xmin_reg;
        xmax_next = (first_reg || sx > xmax_reg) ? sx : xmax_reg;
        ymin_next = (first_reg || sy < ymin_reg) ? sy : ymin_reg;
        ymax_next = (first_reg || sy > ymax_reg) ? sy : ymax_reg;
    end

    logic ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xmin_reg <= '0;
            xmax_reg <= '0;
            ymin_reg <= '0;
            ymax_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fin)
            begin
                xmin_reg <= xmin_next;
                xmax_reg <= xmax_next;
                ymin_reg <= ymin_next;
                ymax_reg <= ymax_next;
                ov_reg <= 1'b1;
            end
            else if (out_take)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            o_sx <= sx;
            o_sy <= sy;
            o_last <= last_reg;
            o_wz <= wz_reg;
        end
    end

    assign out_valid = ov_reg;
    assign o_xmin = xmin_reg;
    assign o_xmax = xmax_reg;
    assign o_ymin = ymin_reg;
    assign o_ymax = ymax_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> !ov_reg || out_take)
        else $error("output word overwritten");
    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> xmin_reg <= xmax_reg || !$past(first_reg))
        else $error("box inverted after first vertex");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> ov_reg)
        else $error("result not presented");

endmodule

`default_nettype wire

@@ design/vertex_screen_projection_bbox_top.sv @@
// ---------------------------------------------------------------------------
// vertex_screen_projection_bbox_top: vertex projection with bounding box
// Projects Q16.16 vertices to viewport pixels and tracks a running box.
// ---------------------------------------------------------------------------
// One vertex at a time: 12 multiply-accumulate terms through one shared
// multiplier, shift-add viewport scaling over 18 factor bits, a prepare step,
// bit-serial division over COORD_BITS+55 quotient bits (both axes in parallel)
// and a finish step. A finished word waits in the output register while the
// next vertex is accepted.
// s_tdata: vertex_x, vertex_y, vertex_z. s_tuser: first_vertex. s_tlast: last.
// m_tdata: screen_x, screen_y, box_x_min, box_x_max, box_y_min, box_y_max.
// m_tuser: w_zero_fault. m_tlast: box_complete.
// ---------------------------------------------------------------------------
`default_nettype none

module vertex_screen_projection_bbox_top
#(
    parameter int COORD_BITS = 32,
    parameter int SCREEN_BITS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // vertex_x, vertex_y, vertex_z from bit 0 up, zero padded
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // first_vertex
    input  wire logic s_tuser,
    input  wire logic s_tlast,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // screen_x, screen_y, box_x_min, box_x_max, box_y_min, box_y_max
    output logic [((6*SCREEN_BITS+7)/8)*8-1:0] m_tdata,
    // w_zero_fault
    output logic m_tuser,
    output logic m_tlast,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [vsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [vsp_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int OW = ((6*SCREEN_BITS+7)/8)*8;

    vsp_pkg::dp_cmd_t cmd;
    vsp_pkg::dp_sts_t sts;
    logic out_valid;
    logic signed [SCREEN_BITS-1:0] sx, sy, xmn, xmx, ymn, ymx;

    assign cfg_ready = 1'b1;

    vsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_tvalid && s_tready),
        .out_free (!out_valid || m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    vsp_datapath #(.COORD_BITS(COORD_BITS), .SCREEN_BITS(SCREEN_BITS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .vx        (s_tdata[COORD_BITS-1:0]),
        .vy        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .vz        (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .vfirst    (s_tuser),
        .vlast     (s_tlast),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_data  (cfg_data),
        .out_take  (m_tready),
        .out_valid (out_valid),
        .o_sx      (sx),
        .o_sy      (sy),
        .o_xmin    (xmn),
        .o_xmax    (xmx),
        .o_ymin    (ymn),
        .o_ymax    (ymx),
        .o_last    (m_tlast),
        .o_wz      (m_tuser)
    );

    assign m_tvalid = out_valid;
    assign m_tdata = OW'({ymx, ymn, xmx, xmn, sy, sx});

endmodule

`default_nettype wire
